// ===== rtl/bdasc_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
// Used by bdasc_out_stage and binary_to_decimal_ascii; depends on nothing else.
package bdasc_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int CHAR_W      = 6;
    localparam int MAX_DIGITS  = 20;
    localparam int POS_W       = $clog2(MAX_DIGITS);
    localparam int DIGIT_W     = 4;
    localparam int WEIGHT_W    = 2;
    // Widest trial term is 8 * 10^19, which needs 67 bits.
    localparam int TERM_W      = 67;

    localparam logic [POS_W-1:0]    TOP_POS     = POS_W'(MAX_DIGITS - 1);
    localparam logic [CHAR_W-1:0]   ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0]   ASCII_MINUS = 6'd45;
    localparam logic                CMD_SIGNED  = 1'b1;

    localparam logic [TERM_W-1:0] POW10 [MAX_DIGITS] = '{
        67'd1,
        67'd10,
        67'd100,
        67'd1000,
        67'd10000,
        67'd100000,
        67'd1000000,
        67'd10000000,
        67'd100000000,
        67'd1000000000,
        67'd10000000000,
        67'd100000000000,
        67'd1000000000000,
        67'd10000000000000,
        67'd100000000000000,
        67'd1000000000000000,
        67'd10000000000000000,
        67'd100000000000000000,
        67'd1000000000000000000,
        67'd10000000000000000000
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_SCAN,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } beat_t;

endpackage

// ===== rtl/bdasc_out_stage.sv =====
// One-entry output register that holds a result beat until the sink takes it.
// Depends on bdasc_pkg for the beat type.
module bdasc_out_stage
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  bdasc_pkg::beat_t                push_beat,
    output logic                            can_push,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bdasc_pkg::CHAR_W-1:0]    char_code,
    output logic                            last
);

    logic             valid_reg;
    logic             valid_next;
    bdasc_pkg::beat_t beat_reg;

    // A new beat may enter when the slot is empty or is being taken this cycle.
    assign can_push   = !valid_reg || !out_stall;
    assign valid_next = push || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            beat_reg <= push_beat;
        end
    end

    assign out_valid = valid_reg;
    assign char_code = beat_reg.char_code;
    assign last      = beat_reg.last;

endmodule

// ===== rtl/binary_to_decimal_ascii.sv =====
// Binary to decimal ASCII converter: one shared compare-subtract unit finds each
// digit, most significant first, against 1, 2, 4 and 8 times a power of ten.
// Sequence: accept, then a '-' if negative, then a scan of the positions from the top down
// to the leading digit, then a compare-subtract against each weight for every digit; the
// '-' and each digit wait while the output register is full. A new item is taken only once
// the last digit has gone to the output register. Reset clears the sequencer and the output
// valid; data registers are not reset.
module binary_to_decimal_ascii
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [63:0]                     value,
    input  logic                            cmd,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bdasc_pkg::CHAR_W-1:0]    char_code,
    output logic                            last
);

    localparam int VW = bdasc_pkg::VALUE_WIDTH;
    localparam int TW = bdasc_pkg::TERM_W;

    bdasc_pkg::state_t                      state_reg;
    bdasc_pkg::state_t                      state_next;
    logic [VW-1:0]                          mag_reg;
    logic [VW-1:0]                          mag_next;
    logic [bdasc_pkg::POS_W-1:0]            pos_reg;
    logic [bdasc_pkg::POS_W-1:0]            pos_next;
    logic [bdasc_pkg::WEIGHT_W-1:0]         weight_reg;
    logic [bdasc_pkg::WEIGHT_W-1:0]         weight_next;
    logic [bdasc_pkg::DIGIT_W-1:0]          digit_reg;
    logic [bdasc_pkg::DIGIT_W-1:0]          digit_next;

    logic [VW-1:0]                          operand;
    logic                                   negative;
    logic [TW-1:0]                          mag_ext;
    logic [TW-1:0]                          term;
    logic [TW-1:0]                          diff;
    logic                                   ge;
    logic [bdasc_pkg::DIGIT_W-1:0]          digit_done;
    logic                                   accept;
    logic                                   push;
    logic                                   can_push;
    bdasc_pkg::beat_t                       push_beat;

    assign operand  = value[VW-1:0];
    assign negative = (cmd == bdasc_pkg::CMD_SIGNED) && operand[VW-1];
    assign in_stall = (state_reg != bdasc_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // The shared unit: the trial term for the current position and weight.
    assign mag_ext    = TW'(mag_reg);
    assign term       = bdasc_pkg::POW10[pos_reg] << weight_reg;
    assign diff       = mag_ext - term;
    assign ge         = !(mag_ext < term);
    assign digit_done = digit_reg | bdasc_pkg::DIGIT_W'(ge);

    always_comb
    begin
        state_next  = state_reg;
        mag_next    = mag_reg;
        pos_next    = pos_reg;
        weight_next = weight_reg;
        digit_next  = digit_reg;
        push        = 1'b0;
        push_beat   = '{char_code: bdasc_pkg::ASCII_ZERO, last: 1'b0};

        case (state_reg)
            bdasc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    mag_next    = negative ? (~operand + VW'(1)) : operand;
                    pos_next    = bdasc_pkg::TOP_POS;
                    weight_next = '0;
                    state_next  = negative ? bdasc_pkg::ST_SIGN : bdasc_pkg::ST_SCAN;
                end
            end
            bdasc_pkg::ST_SIGN:
            begin
                if (can_push)
                begin
                    push       = 1'b1;
                    push_beat  = '{char_code: bdasc_pkg::ASCII_MINUS, last: 1'b0};
                    state_next = bdasc_pkg::ST_SCAN;
                end
            end
            bdasc_pkg::ST_SCAN:
            begin
                // Skip leading zero positions; the units position is always printed.
                if ((pos_reg != '0) && !ge)
                begin
                    pos_next = pos_reg - bdasc_pkg::POS_W'(1);
                end
                else
                begin
                    weight_next = '1;
                    digit_next  = '0;
                    state_next  = bdasc_pkg::ST_DIGIT;
                end
            end
            bdasc_pkg::ST_DIGIT:
            begin
                if (weight_reg != '0)
                begin
                    if (ge)
                    begin
                        mag_next = diff[VW-1:0];
                    end
                    digit_next  = digit_done << 1;
                    weight_next = weight_reg - bdasc_pkg::WEIGHT_W'(1);
                end
                else if (can_push)
                begin
                    if (ge)
                    begin
                        mag_next = diff[VW-1:0];
                    end
                    push      = 1'b1;
                    push_beat = '{char_code: bdasc_pkg::ASCII_ZERO
                                             + bdasc_pkg::CHAR_W'(digit_done),
                                  last: (pos_reg == '0)};
                    if (pos_reg == '0)
                    begin
                        state_next = bdasc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pos_next    = pos_reg - bdasc_pkg::POS_W'(1);
                        weight_next = '1;
                        digit_next  = '0;
                    end
                end
            end
            default:
            begin
                state_next = bdasc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdasc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        pos_reg    <= pos_next;
        weight_reg <= weight_next;
        digit_reg  <= digit_next;
    end

    bdasc_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_beat (push_beat),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last      (last)
    );

endmodule
